[hw/rtl/tfr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tfr_pkg
// Shared screen geometry, command codes, controller states and the control
// and status bundles between the text renderer controller and datapath.
// ----------------------------------------------------------------------------
package tfr_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
  localparam int BUF_BYTES     = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W        = $clog2(BUF_BYTES);

  localparam int FONT_W      = 5;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 24;

  localparam logic [FONT_W-1:0] FONT_WIDTH_RST  = 5'd7;
  localparam logic [FONT_W-1:0] FONT_HEIGHT_RST = 5'd10;
  localparam logic [15:0]       PIXEL_BITS      = 16'h8000;
  localparam logic [7:0]        BYTE_WHITE      = 8'hFF;
  localparam logic [7:0]        BYTE_BLACK      = 8'h00;

  // Configuration register indexes
  localparam logic REG_FONT_WIDTH  = 1'b0;
  localparam logic REG_FONT_HEIGHT = 1'b1;

  // Command codes
  localparam logic [2:0] CMD_FILL   = 3'd0;
  localparam logic [2:0] CMD_PIXEL  = 3'd1;
  localparam logic [2:0] CMD_CURSOR = 3'd2;
  localparam logic [2:0] CMD_GLYPH  = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_FILL,
    ST_DRAW,
    ST_READ,
    ST_DONE
  } tfr_state_t;

  typedef struct packed {
    logic capture;
    logic dispatch;
    logic sweep_wr;
    logic draw_step;
    logic rd_issue;
    logic load_out;
  } dp_ctrl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       fits;
    logic       sweep_last;
    logic       draw_done;
    logic       out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

[hw/rtl/tfr_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tfr_ctrl
// Command sequencer: clears the buffer after reset, takes one request at a
// time, steps the datapath through fill, draw or read, and hands off result.
// ----------------------------------------------------------------------------
module tfr_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  tfr_pkg::dp_stat_t stat,
  output tfr_pkg::dp_ctrl_t ctrl
);
  import tfr_pkg::*;

  tfr_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (stat.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (stat.cmd)
          CMD_FILL:  state_next = ST_FILL;
          CMD_PIXEL: state_next = ST_DRAW;
          CMD_GLYPH: state_next = stat.fits ? ST_DRAW : ST_DONE;
          CMD_READ:  state_next = ST_READ;
          default:   state_next = ST_DONE;
        endcase
      end
      ST_FILL: begin
        if (stat.sweep_last) state_next = ST_DONE;
      end
      ST_DRAW: begin
        if (stat.draw_done) state_next = ST_DONE;
      end
      ST_READ: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready       = (state == ST_IDLE);
    ctrl.capture   = (state == ST_IDLE) && in_valid;
    ctrl.dispatch  = (state == ST_DISPATCH);
    ctrl.sweep_wr  = (state == ST_CLEAR) || (state == ST_FILL);
    ctrl.draw_step = (state == ST_DRAW);
    ctrl.rd_issue  = (state == ST_READ);
    ctrl.load_out  = (state == ST_DONE) && stat.out_free;
  end

endmodule
`default_nettype wire

[hw/rtl/tfr_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tfr_datapath
// Frame buffer memory, text cursor, font registers, column draw pipeline
// (read one byte, modify one bit, write back) and the result register.
// ----------------------------------------------------------------------------
module tfr_datapath (
  input  wire                         clk,
  input  wire                         rst,
  input  tfr_pkg::dp_ctrl_t           ctrl,
  output tfr_pkg::dp_stat_t           stat,
  input  wire                         cfg_we,
  input  wire                         cfg_addr,
  input  wire  [tfr_pkg::FONT_W-1:0]  cfg_wdata,
  input  wire  [2:0]                  in_cmd,
  input  wire  [7:0]                  in_pos_x,
  input  wire  [7:0]                  in_pos_y,
  input  wire                         in_colour,
  input  wire  [15:0]                 in_bits,
  input  wire  [3:0]                  in_row_index,
  input  wire                         in_last_row,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic                        out_status,
  output logic [7:0]                  out_read_data,
  output logic [7:0]                  out_cursor_col,
  output logic [7:0]                  out_cursor_row
);
  import tfr_pkg::*;

  logic [7:0] mem [BUF_BYTES];

  // Latched request
  logic [2:0]  cmd_q;
  logic [7:0]  pos_x_q, pos_y_q;
  logic        colour_q, last_q;
  logic [15:0] bits_q;
  logic [3:0]  ridx_q;

  logic [FONT_W-1:0] font_width, font_height;
  logic [7:0]        text_col, text_row;

  logic [ADDR_W-1:0] sweep_cnt;
  logic [7:0]        fill_val;
  logic              sweep_last;

  // Column draw unit
  logic [7:0]        draw_x;
  logic [8:0]        draw_y;
  logic [15:0]       draw_bits;
  logic [FONT_W-1:0] draw_n, draw_j;
  logic              draw_col;
  logic              pend, pend_on;
  logic [ADDR_W-1:0] pend_addr;
  logic [7:0]        pend_mask;

  logic [8:0]        col_x;
  logic              col_ok, col_on, col_issue;
  logic [ADDR_W-1:0] col_addr;

  logic              fits;
  logic              rd_ok, rd_ok_q, status_q;
  logic [ADDR_W-1:0] rd_addr_cmd;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_wa, mem_ra;
  logic [7:0]        mem_wd, rd_q;

  assign sweep_last = (sweep_cnt == ADDR_W'(BUF_BYTES - 1));
  assign fits = ((9'(text_col) + 9'(font_width)) < 9'(SCREEN_WIDTH)) &&
                ((9'(text_row) + 9'(font_height)) < 9'(SCREEN_HEIGHT));

  assign col_x     = 9'(draw_x) + 9'(draw_j);
  assign col_ok    = (col_x < 9'(SCREEN_WIDTH)) && (draw_y < 9'(SCREEN_HEIGHT));
  // Columns from sixteen on have no font bit
  assign col_on    = (draw_j < FONT_W'(16)) && draw_bits[4'd15 - draw_j[3:0]];
  assign col_issue = ctrl.draw_step && (draw_j < draw_n);
  assign col_addr  = ADDR_W'(col_x) + ADDR_W'(draw_y[8:3]) * ADDR_W'(SCREEN_WIDTH);

  assign rd_ok       = (9'(pos_x_q) < 9'(SCREEN_WIDTH)) && (9'(pos_y_q) < 9'(PAGE_COUNT));
  assign rd_addr_cmd = ADDR_W'(pos_x_q) + ADDR_W'(pos_y_q) * ADDR_W'(SCREEN_WIDTH);

  always_comb begin
    stat.cmd        = cmd_q;
    stat.fits       = fits;
    stat.sweep_last = sweep_last;
    stat.draw_done  = (draw_j == draw_n);
    stat.out_free   = !out_valid || out_ready;
  end

  // Memory port selection
  always_comb begin
    mem_we = ctrl.sweep_wr || pend;
    mem_wa = ctrl.sweep_wr ? sweep_cnt : pend_addr;
    if (ctrl.sweep_wr) begin
      mem_wd = fill_val;
    end else if (pend_on) begin
      mem_wd = rd_q | pend_mask;
    end else begin
      mem_wd = rd_q & ~pend_mask;
    end
    mem_re = col_issue || (ctrl.rd_issue && rd_ok);
    mem_ra = ctrl.rd_issue ? rd_addr_cmd : col_addr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= mem[mem_ra];
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_q    <= in_cmd;
      pos_x_q  <= in_pos_x;
      pos_y_q  <= in_pos_y;
      colour_q <= in_colour;
      bits_q   <= in_bits;
      ridx_q   <= in_row_index;
      last_q   <= in_last_row;
    end
  end

  // Configuration and cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      font_width  <= FONT_WIDTH_RST;
      font_height <= FONT_HEIGHT_RST;
      text_col    <= '0;
      text_row    <= '0;
      status_q    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_FONT_WIDTH:  font_width  <= cfg_wdata;
          REG_FONT_HEIGHT: font_height <= cfg_wdata;
          default: ;
        endcase
      end
      if (ctrl.dispatch) begin
        status_q <= (cmd_q == CMD_GLYPH) && !fits;
        if (cmd_q == CMD_CURSOR) begin
          text_col <= pos_x_q;
          text_row <= pos_y_q;
        end else if ((cmd_q == CMD_GLYPH) && fits && last_q) begin
          text_col <= text_col + 8'(font_width);
        end
      end
    end
  end

  // Clear and fill sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
      fill_val  <= BYTE_BLACK;
    end else begin
      if (ctrl.dispatch && (cmd_q == CMD_FILL)) begin
        fill_val <= colour_q ? BYTE_WHITE : BYTE_BLACK;
      end
      if (ctrl.sweep_wr) begin
        sweep_cnt <= sweep_last ? '0 : sweep_cnt + 1'b1;
      end
    end
  end

  // Draw setup: a pixel is a one-column glyph row with only its left bit set
  always_ff @(posedge clk) begin
    if (ctrl.dispatch) begin
      draw_j   <= '0;
      draw_col <= colour_q;
      if (cmd_q == CMD_PIXEL) begin
        draw_x    <= pos_x_q;
        draw_y    <= 9'(pos_y_q);
        draw_bits <= PIXEL_BITS;
        draw_n    <= FONT_W'(1);
      end else begin
        draw_x    <= text_col;
        draw_y    <= 9'(text_row) + 9'(ridx_q);
        draw_bits <= bits_q;
        draw_n    <= font_width;
      end
    end else if (col_issue) begin
      draw_j <= draw_j + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= col_issue && col_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (col_issue) begin
      pend_addr <= col_addr;
      pend_mask <= 8'(1) << draw_y[2:0];
      pend_on   <= col_on ? draw_col : !draw_col;
    end
    if (ctrl.rd_issue) begin
      rd_ok_q <= rd_ok;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      out_status     <= status_q;
      out_read_data  <= ((cmd_q == CMD_READ) && rd_ok_q) ? rd_q : 8'h00;
      out_cursor_col <= text_col;
      out_cursor_row <= text_row;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/text_framebuffer_renderer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// text_framebuffer_renderer
// Page-organized monochrome frame buffer with a text cursor.
//
// Requests enter on the s_ stream: s_tuser carries the command (fill, pixel,
// set cursor, glyph row, read byte), s_tlast marks the last row of a glyph.
// Every request yields exactly one result on the m_ stream: m_tuser is the
// glyph reject flag, m_tdata the read byte and the cursor after the request.
// The user writes font width and height on the cfg_ port only while the block
// is idle; the block itself does not enforce this.
// Cursor, rejected glyph and unknown commands go from dispatch straight to the
// result; a read fetches one byte (00 out of range); a pixel or glyph row runs
// the column draw; a fill sweeps the buffer. The column draw does one
// read-modify-write per cycle on the separate read and write ports of the
// buffer memory, and fill walks all 1024 bytes at one a cycle. One request is
// in work at a time; the next is accepted the cycle after the result is
// loaded, even while that result still waits in the output register, which
// holds while m_tready is low.
// While the buffer is cleared after reset, s_tready
// stays low; cfg_ writes are taken at any time.
// ----------------------------------------------------------------------------
module text_framebuffer_renderer (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  // pos_x[7:0], pos_y[15:8], colour[16], glyph_row_bits[32:17], row_index[36:33]
  input  wire  [tfr_pkg::IN_DATA_W-1:0]    s_tdata,
  // cmd[2:0]
  input  wire  [2:0]                       s_tuser,
  input  wire                              s_tlast,
  output logic                             m_tvalid,
  input  wire                              m_tready,
  // read_data[7:0], cursor_col[15:8], cursor_row[23:16]
  output logic [tfr_pkg::OUT_DATA_W-1:0]   m_tdata,
  // status[0]
  output logic                             m_tuser,
  input  wire                              cfg_we,
  input  wire                              cfg_addr,
  input  wire  [tfr_pkg::FONT_W-1:0]       cfg_wdata
);
  import tfr_pkg::*;

  dp_ctrl_t   ctrl;
  dp_stat_t   stat;
  logic [7:0] read_data, cursor_col, cursor_row;

  tfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  tfr_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_cmd         (s_tuser),
    .in_pos_x       (s_tdata[7:0]),
    .in_pos_y       (s_tdata[15:8]),
    .in_colour      (s_tdata[16]),
    .in_bits        (s_tdata[32:17]),
    .in_row_index   (s_tdata[36:33]),
    .in_last_row    (s_tlast),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_status     (m_tuser),
    .out_read_data  (read_data),
    .out_cursor_col (cursor_col),
    .out_cursor_row (cursor_row)
  );

  assign m_tdata = {cursor_row, cursor_col, read_data};

endmodule
`default_nettype wire
